### hdl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants and tables for the quaternion to euler angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

	// default build values
	localparam int QUAT_WIDTH_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	// working formats
	localparam int WFRAC      = 28;          // fraction bits of products and sums
	localparam int Q28_W      = 32;          // one scaled product
	localparam int ARG_W      = 36;          // atan2 arguments
	localparam int TABLE_LEN  = 24;          // arctangent table length
	localparam int SQ_STEPS   = 29;          // result bits of the square root
	localparam int RAD_W      = 58;          // radicand and root working width
	localparam int ANGLE_W    = 32;          // binary angle, 2^32 = one turn
	localparam int CDEG_W     = 16;
	localparam int PITCH_W    = 15;
	localparam int SCALE_W    = 17;
	localparam int CDEG_PROD_W = ANGLE_W + SCALE_W;

	localparam logic signed [SCALE_W-1:0] CDEG_SCALE = 17'sd36000;
	localparam logic signed [CDEG_W-1:0]  PITCH_MAX  = 16'sd9000;
	localparam logic signed [CDEG_W-1:0]  PITCH_MIN  = -16'sd9000;
	localparam logic [ANGLE_W-1:0]        HALF_TURN  = 32'h8000_0000;

	// arctangent of 2^-i as a binary angle
	function automatic logic [ANGLE_W-1:0] atan_entry(input int i);
		logic [ANGLE_W-1:0] a;
		case (i)
			0:  a = 32'd536870912;
			1:  a = 32'd316933406;
			2:  a = 32'd167458907;
			3:  a = 32'd85004756;
			4:  a = 32'd42667331;
			5:  a = 32'd21354465;
			6:  a = 32'd10680862;
			7:  a = 32'd5340245;
			8:  a = 32'd2670163;
			9:  a = 32'd1335087;
			10: a = 32'd667544;
			11: a = 32'd333772;
			12: a = 32'd166886;
			13: a = 32'd83443;
			14: a = 32'd41722;
			15: a = 32'd20861;
			16: a = 32'd10430;
			17: a = 32'd5215;
			18: a = 32'd2608;
			19: a = 32'd1304;
			20: a = 32'd652;
			21: a = 32'd326;
			22: a = 32'd163;
			23: a = 32'd81;
			default: a = '0;
		endcase
		return a;
	endfunction

	// iterations actually built, capped at the table length
	function automatic int cordic_iters(input int n);
		return (n > TABLE_LEN) ? TABLE_LEN : n;
	endfunction

	// register stages of one cordic unit: prep, iterations, scale, round
	function automatic int cordic_latency(input int n);
		return cordic_iters(n) + 3;
	endfunction

endpackage

`default_nettype wire

### hdl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// ZYX euler angles in centidegrees from a fixed point rotation quaternion.
//
//  channel   signals                                   handshake
//  --------  ----------------------------------------  -------------------------
//  command   quat_w quat_x quat_y quat_z               start high, busy low
//  result    roll_cdeg pitch_cdeg yaw_cdeg              done high for one cycle
//            pitch_clamped
//
// One beat enters every cycle; busy never rises. A result passes the products,
// the argument stages, the 29 stage square root and then the three cordic units
// before it leaves.
// Reset clears only the valid bits of the pipeline; results cannot be held
// off, so nothing ever stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles #(
	parameter int QUAT_WIDTH    = qte_pkg::QUAT_WIDTH_DEF,
	parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [QUAT_WIDTH-1:0]          quat_w,
	input  wire logic signed [QUAT_WIDTH-1:0]          quat_x,
	input  wire logic signed [QUAT_WIDTH-1:0]          quat_y,
	input  wire logic signed [QUAT_WIDTH-1:0]          quat_z,
	output logic                                       done,
	output logic signed [qte_pkg::CDEG_W-1:0]          roll_cdeg,
	output logic signed [qte_pkg::PITCH_W-1:0]         pitch_cdeg,
	output logic signed [qte_pkg::CDEG_W-1:0]          yaw_cdeg,
	output logic                                       pitch_clamped
);

	localparam int QF    = QUAT_WIDTH - 2;
	localparam int SH    = 2 * QF - qte_pkg::WFRAC;
	localparam int SHR   = (SH >= 0) ? SH : 0;
	localparam int SHL   = (SH < 0) ? -SH : 0;
	localparam int PW    = 2 * QUAT_WIDTH;
	localparam int QW28  = qte_pkg::Q28_W;
	localparam int AW    = qte_pkg::ARG_W;
	localparam int RW    = qte_pkg::RAD_W;
	localparam int NSQ   = qte_pkg::SQ_STEPS;
	localparam int SW    = qte_pkg::WFRAC + 1;
	localparam int LAT   = qte_pkg::cordic_latency(CORDIC_STAGES);
	localparam logic signed [AW-1:0] ONE = AW'(1) <<< qte_pkg::WFRAC;

	// scale a full product to Q28
	function automatic logic signed [QW28-1:0] to_q28(input logic signed [PW-1:0] p);
		logic signed [63:0] e;
		e = 64'(p);
		e = (e >>> SHR) <<< SHL;
		return e[QW28-1:0];
	endfunction

	assign busy = 1'b0;

	// stage 1: the nine products
	logic signed [QW28-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;
	logic                   vld_s1;

	always_ff @(posedge clk) begin
		wx_s1 <= to_q28(quat_w * quat_x);
		yz_s1 <= to_q28(quat_y * quat_z);
		xx_s1 <= to_q28(quat_x * quat_x);
		yy_s1 <= to_q28(quat_y * quat_y);
		wz_s1 <= to_q28(quat_w * quat_z);
		xy_s1 <= to_q28(quat_x * quat_y);
		zz_s1 <= to_q28(quat_z * quat_z);
		wy_s1 <= to_q28(quat_w * quat_y);
		zx_s1 <= to_q28(quat_z * quat_x);
	end

	// stage 2: atan2 arguments and the asin argument
	logic signed [AW-1:0] roll_y_s2, roll_x_s2, yaw_y_s2, yaw_x_s2, sinp_s2;
	logic                 vld_s2;

	always_ff @(posedge clk) begin
		roll_y_s2 <= (AW'(wx_s1) + AW'(yz_s1)) <<< 1;
		roll_x_s2 <= ONE - ((AW'(xx_s1) + AW'(yy_s1)) <<< 1);
		yaw_y_s2  <= (AW'(wz_s1) + AW'(xy_s1)) <<< 1;
		yaw_x_s2  <= ONE - ((AW'(yy_s1) + AW'(zz_s1)) <<< 1);
		sinp_s2   <= (AW'(wy_s1) - AW'(zx_s1)) <<< 1;
	end

	// stage 3: clamp test and square of the asin argument
	logic signed [AW-1:0] roll_y_s3, roll_x_s3, yaw_y_s3, yaw_x_s3;
	logic signed [SW-1:0] sinp_s3;
	logic        [RW-1:0] sq_s3;
	logic                 clamp_s3, neg_s3, vld_s3;
	logic signed [RW-1:0] sinp_sq;

	// full width square, operands sign extended by the assignment
	assign sinp_sq = $signed(sinp_s2[SW-1:0]) * $signed(sinp_s2[SW-1:0]);

	always_ff @(posedge clk) begin
		roll_y_s3 <= roll_y_s2;
		roll_x_s3 <= roll_x_s2;
		yaw_y_s3  <= yaw_y_s2;
		yaw_x_s3  <= yaw_x_s2;
		sinp_s3   <= sinp_s2[SW-1:0];
		sq_s3     <= $unsigned(sinp_sq);
		clamp_s3  <= (sinp_s2 >= ONE) || (sinp_s2 <= -ONE);
		neg_s3    <= sinp_s2[AW-1];
	end

	// square root pipeline, entry 0 is the radicand stage
	logic        [RW-1:0] sqn_s  [0:NSQ];
	logic        [RW-1:0] sqr_s  [0:NSQ];
	logic signed [AW-1:0] ry_s   [0:NSQ];
	logic signed [AW-1:0] rx_s   [0:NSQ];
	logic signed [AW-1:0] yy_d_s [0:NSQ];
	logic signed [AW-1:0] yx_s   [0:NSQ];
	logic signed [SW-1:0] sp_s   [0:NSQ];
	logic                 clp_s  [0:NSQ];
	logic                 neg_s  [0:NSQ];
	logic                 vld_q  [0:NSQ];

	always_ff @(posedge clk) begin
		sqn_s[0]  <= (RW'(1) << (2 * qte_pkg::WFRAC)) - sq_s3;
		sqr_s[0]  <= '0;
		ry_s[0]   <= roll_y_s3;
		rx_s[0]   <= roll_x_s3;
		yy_d_s[0] <= yaw_y_s3;
		yx_s[0]   <= yaw_x_s3;
		sp_s[0]   <= sinp_s3;
		clp_s[0]  <= clamp_s3;
		neg_s[0]  <= neg_s3;
	end

	// one root bit per stage
	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		logic [RW-1:0] bitv;
		logic [RW-1:0] trial;
		assign bitv  = RW'(1) << (2 * (NSQ - 1 - k));
		assign trial = sqr_s[k] + bitv;

		always_ff @(posedge clk) begin
			if (sqn_s[k] >= trial) begin
				sqn_s[k+1] <= sqn_s[k] - trial;
				sqr_s[k+1] <= (sqr_s[k] >> 1) + bitv;
			end else begin
				sqn_s[k+1] <= sqn_s[k];
				sqr_s[k+1] <= sqr_s[k] >> 1;
			end
			ry_s[k+1]   <= ry_s[k];
			rx_s[k+1]   <= rx_s[k];
			yy_d_s[k+1] <= yy_d_s[k];
			yx_s[k+1]   <= yx_s[k];
			sp_s[k+1]   <= sp_s[k];
			clp_s[k+1]  <= clp_s[k];
			neg_s[k+1]  <= neg_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else begin
				vld_q[k+1] <= vld_q[k];
			end
		end
	end

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_q[0] <= 1'b0;
		end else begin
			vld_s1   <= start;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_q[0] <= vld_s3;
		end
	end

	// three angle units
	logic                                 roll_vld, pitch_vld, yaw_vld;
	logic signed [qte_pkg::CDEG_W-1:0]    roll_c, pitch_c, yaw_c;
	logic signed [AW-1:0]                 pitch_y, pitch_x;

	assign pitch_y = AW'(sp_s[NSQ]);
	assign pitch_x = $signed(sqr_s[NSQ][AW-1:0]);

	qte_cordic #(.IN_W(AW), .STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_q[NSQ]),
		.in_y(ry_s[NSQ]), .in_x(rx_s[NSQ]),
		.out_valid(roll_vld), .out_cdeg(roll_c)
	);

	qte_cordic #(.IN_W(AW), .STAGES(CORDIC_STAGES)) u_pitch (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_q[NSQ]),
		.in_y(pitch_y), .in_x(pitch_x),
		.out_valid(pitch_vld), .out_cdeg(pitch_c)
	);

	qte_cordic #(.IN_W(AW), .STAGES(CORDIC_STAGES)) u_yaw (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_q[NSQ]),
		.in_y(yy_d_s[NSQ]), .in_x(yx_s[NSQ]),
		.out_valid(yaw_vld), .out_cdeg(yaw_c)
	);

	// clamp flag and sign ride alongside the cordic units
	logic clp_c_s [0:LAT-1];
	logic neg_c_s [0:LAT-1];

	always_ff @(posedge clk) begin
		clp_c_s[0] <= clp_s[NSQ];
		neg_c_s[0] <= neg_s[NSQ];
		for (int j = 1; j < LAT; j++) begin
			clp_c_s[j] <= clp_c_s[j-1];
			neg_c_s[j] <= neg_c_s[j-1];
		end
	end

	// pitch: forced to a pole or saturated
	logic signed [qte_pkg::CDEG_W-1:0] pitch_sel;

	always_comb begin
		if (clp_c_s[LAT-1]) begin
			pitch_sel = neg_c_s[LAT-1] ? qte_pkg::PITCH_MIN : qte_pkg::PITCH_MAX;
		end else if (pitch_c > qte_pkg::PITCH_MAX) begin
			pitch_sel = qte_pkg::PITCH_MAX;
		end else if (pitch_c < qte_pkg::PITCH_MIN) begin
			pitch_sel = qte_pkg::PITCH_MIN;
		end else begin
			pitch_sel = pitch_c;
		end
	end

	// result beat register
	always_ff @(posedge clk) begin
		roll_cdeg     <= roll_c;
		yaw_cdeg      <= yaw_c;
		pitch_cdeg    <= pitch_sel[qte_pkg::PITCH_W-1:0];
		pitch_clamped <= clp_c_s[LAT-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= roll_vld & pitch_vld & yaw_vld;
		end
	end

endmodule

`default_nettype wire

### hdl/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring cordic: atan2(y, x) rounded to centidegrees.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic #(
	parameter int IN_W   = qte_pkg::ARG_W,
	parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic signed [IN_W-1:0]               in_y,
	input  wire logic signed [IN_W-1:0]               in_x,
	output logic                                      out_valid,
	output logic signed [qte_pkg::CDEG_W-1:0]         out_cdeg
);

	localparam int ITERS = qte_pkg::cordic_iters(STAGES);
	localparam int CW    = IN_W + 2;
	localparam int AW    = qte_pkg::ANGLE_W;
	localparam int PW    = qte_pkg::CDEG_PROD_W;

	logic signed [CW-1:0] x_s    [0:ITERS];
	logic signed [CW-1:0] y_s    [0:ITERS];
	logic        [AW-1:0] z_s    [0:ITERS];
	logic                 zero_s [0:ITERS];
	logic                 vld_s  [0:ITERS];

	logic signed [PW-1:0] prod_sm;
	logic                 zero_sm;
	logic                 vld_sm;

	logic signed [CW-1:0] x_ext;
	logic signed [CW-1:0] y_ext;
	logic signed [PW-1:0] rnd_sum;

	// prep: turn left half plane vectors by half a turn
	assign x_ext = CW'(in_x);
	assign y_ext = CW'(in_y);

	always_ff @(posedge clk) begin
		if (in_x[IN_W-1]) begin
			x_s[0] <= -x_ext;
			y_s[0] <= -y_ext;
			z_s[0] <= qte_pkg::HALF_TURN;
		end else begin
			x_s[0] <= x_ext;
			y_s[0] <= y_ext;
			z_s[0] <= '0;
		end
		zero_s[0] <= (in_x == '0) && (in_y == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (!y_s[i][CW-1]) begin
				x_s[i+1] <= x_s[i] + ys;
				y_s[i+1] <= y_s[i] - xs;
				z_s[i+1] <= z_s[i] + qte_pkg::atan_entry(i);
			end else begin
				x_s[i+1] <= x_s[i] - ys;
				y_s[i+1] <= y_s[i] + xs;
				z_s[i+1] <= z_s[i] - qte_pkg::atan_entry(i);
			end
			zero_s[i+1] <= zero_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
	end

	// scale binary angle to centidegrees
	always_ff @(posedge clk) begin
		prod_sm <= $signed(z_s[ITERS]) * qte_pkg::CDEG_SCALE;
		zero_sm <= zero_s[ITERS];
	end

	// round half up and drop the 32 fraction bits
	assign rnd_sum = prod_sm + (PW'(1) <<< 31);

	always_ff @(posedge clk) begin
		out_cdeg <= zero_sm ? '0 : rnd_sum[AW +: qte_pkg::CDEG_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sm    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			vld_sm    <= vld_s[ITERS];
			out_valid <= vld_sm;
		end
	end

endmodule

`default_nettype wire

### dv/quaternion_to_euler_angles_checker.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_checker
// Watches the command and result channels of the euler angle block, computes
// the expected roll, pitch, yaw and clamp flag for every accepted command and
// compares each result beat against the oldest pending expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic signed [15:0] quat_w,
	input  wire logic signed [15:0] quat_x,
	input  wire logic signed [15:0] quat_y,
	input  wire logic signed [15:0] quat_z,
	input  wire logic               done,
	input  wire logic signed [15:0] roll_cdeg,
	input  wire logic signed [14:0] pitch_cdeg,
	input  wire logic signed [15:0] yaw_cdeg,
	input  wire logic               pitch_clamped,
	output int                      fail_count,
	output int                      pending,
	output int                      clamp_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic               clamped;
	} angles_t;

	angles_t angles_q[$];

	localparam int QFRAC = 14;
	localparam int STAGES = 16;

	// product of two parts brought to q28 (14 + 14 fraction bits, exact)
	function automatic longint prod_q28(input longint a, input longint b);
		return (a * b) <<< (qte_pkg::WFRAC - 2 * QFRAC);
	endfunction

	function automatic longint root_floor(input longint n);
		longint r;
		longint b;
		r = 0;
		b = 64'sh4000_0000_0000_0000;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	// vectoring cordic, binary angle output
	function automatic logic [31:0] vector_angle(input longint vy, input longint vx);
		logic [31:0] ang;
		longint xs;
		longint ys;
		ang = '0;
		if (vx == 0 && vy == 0) return '0;
		if (vx < 0) begin
			ang = qte_pkg::HALF_TURN;
			vx = -vx;
			vy = -vy;
		end
		for (int i = 0; i < STAGES; i++) begin
			xs = vx >>> i;
			ys = vy >>> i;
			if (vy >= 0) begin
				vx = vx + ys;
				vy = vy - xs;
				ang = ang + qte_pkg::atan_entry(i);
			end else begin
				vx = vx - ys;
				vy = vy + xs;
				ang = ang - qte_pkg::atan_entry(i);
			end
		end
		return ang;
	endfunction

	function automatic longint angle_cdeg(input logic [31:0] a);
		longint s;
		s = longint'(signed'(a));
		return (s * 36000 + 64'sd2147483648) >>> 32;
	endfunction

	function automatic angles_t euler_of(input longint w, input longint x,
			input longint y, input longint z);
		angles_t r;
		longint one;
		longint sinp;
		longint c;
		longint p;
		one = 64'sd1 <<< qte_pkg::WFRAC;
		r.roll = 16'(angle_cdeg(vector_angle(2 * (prod_q28(w, x) + prod_q28(y, z)),
			one - 2 * (prod_q28(x, x) + prod_q28(y, y)))));
		r.yaw = 16'(angle_cdeg(vector_angle(2 * (prod_q28(w, z) + prod_q28(x, y)),
			one - 2 * (prod_q28(y, y) + prod_q28(z, z)))));
		sinp = 2 * (prod_q28(w, y) - prod_q28(z, x));
		if (sinp >= one || sinp <= -one) begin
			p = (sinp > 0) ? 9000 : -9000;
			r.clamped = 1'b1;
		end else begin
			c = root_floor((64'sd1 <<< 56) - sinp * sinp);
			p = angle_cdeg(vector_angle(sinp, c));
			if (p > 9000) p = 9000;
			if (p < -9000) p = -9000;
			r.clamped = 1'b0;
		end
		r.pitch = 15'(p);
		return r;
	endfunction

	// predict on command beats, compare on result beats
	always @(posedge clk or negedge arst_n) begin
		angles_t exp_a;
		if (!arst_n) begin
			angles_q.delete();
			fail_count <= 0;
			pending <= 0;
			clamp_seen <= 0;
		end else begin
			if (start && !busy) begin
				exp_a = euler_of(quat_w, quat_x, quat_y, quat_z);
				if (exp_a.clamped) clamp_seen <= clamp_seen + 1;
				angles_q.push_back(exp_a);
			end
			if (done) begin
				if (angles_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected result beat at %0t", $realtime);
					fail_count <= fail_count + 1;
				end else begin
					exp_a = angles_q.pop_front();
					if (exp_a.roll !== roll_cdeg || exp_a.pitch !== pitch_cdeg ||
							exp_a.yaw !== yaw_cdeg || exp_a.clamped !== pitch_clamped) begin
						if (fail_count < 10)
							$display("mismatch: exp r=%0d p=%0d y=%0d c=%0b got r=%0d p=%0d y=%0d c=%0b",
								exp_a.roll, exp_a.pitch, exp_a.yaw, exp_a.clamped,
								roll_cdeg, pitch_cdeg, yaw_cdeg, pitch_clamped);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= angles_q.size();
		end
	end

endmodule

`default_nettype wire

### dv/quaternion_to_euler_angles_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb
// Drives directed and random quaternions with random gaps into the euler
// angle block; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 16 + 37;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_BEATS = 540;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic done;
	logic signed [15:0] roll_cdeg, yaw_cdeg;
	logic signed [14:0] pitch_cdeg;
	logic pitch_clamped;
	int fail_count, pending, clamp_seen;
	int beats_sent = 0;
	int idle_cycles = 0;

	always #6 clk = ~clk;

	quaternion_to_euler_angles u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.done(done), .roll_cdeg(roll_cdeg), .pitch_cdeg(pitch_cdeg),
		.yaw_cdeg(yaw_cdeg), .pitch_clamped(pitch_clamped)
	);

	quaternion_to_euler_angles_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.done(done), .roll_cdeg(roll_cdeg), .pitch_cdeg(pitch_cdeg),
		.yaw_cdeg(yaw_cdeg), .pitch_clamped(pitch_clamped),
		.fail_count(fail_count), .pending(pending), .clamp_seen(clamp_seen)
	);

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** quaternion_to_euler_angles: FAILED **");
			$finish;
		end
	end

	// one command beat, with a random gap in front when use_gap is set, held until accepted
	task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] z, input bit use_gap);
		int gap;
		gap = use_gap ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		quat_w <= w;
		quat_x <= x;
		quat_y <= y;
		quat_z <= z;
		do @(posedge clk); while (busy);
		beats_sent++;
	endtask

	// random unit quaternion scaled to q14, with some jitter on the length
	task automatic send_unit(input bit use_gap);
		real a, b, c, d, n;
		int jit;
		a = $urandom_range(0, 65535) - 32768.0;
		b = $urandom_range(0, 65535) - 32768.0;
		c = $urandom_range(0, 65535) - 32768.0;
		d = $urandom_range(0, 65535) - 32768.0;
		n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
		jit = $urandom_range(0, 6) - 3;
		send_quat(16'($rtoi(16384.0 * a / n) + jit), 16'($rtoi(16384.0 * b / n)),
			16'($rtoi(16384.0 * c / n)), 16'($rtoi(16384.0 * d / n) - jit), use_gap);
	endtask

	initial begin
		int mode;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity, axis turns, gimbal lock, zeros and extremes
		send_quat(16'sd16384, 0, 0, 0, 0);
		send_quat(0, 16'sd16384, 0, 0, 0);
		send_quat(0, 0, 16'sd16384, 0, 0);
		send_quat(0, 0, 0, 16'sd16384, 0);
		send_quat(-16'sd16384, 0, 0, 0, 0);
		send_quat(16'sd11585, 0, 16'sd11585, 0, 0);
		send_quat(16'sd11585, 0, -16'sd11585, 0, 0);
		send_quat(16'sd11585, 16'sd11585, 16'sd11585, -16'sd11585, 1);
		send_quat(16'sd11585, 0, 16'sd11584, 0, 1);
		send_quat(0, 0, 0, 0, 0);
		send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
		send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);
		send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1);
		send_quat(16'sd11585, 16'sd11585, 0, 0, 0);
		send_quat(0, 16'sd11585, 16'sd11585, 0, 0);
		send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 0);
		send_quat(0, 0, 16'sd11585, 16'sd11585, 1);
		send_quat(16'sd1, 16'sd16384, 0, 16'sd1, 0);
		send_quat(-16'sd1, 16'sd16384, 0, -16'sd1, 0);

		// let the pipe drain completely before the random part
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || done);

		// random: mostly unit quaternions, some raw noise, bursts without gaps
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			mode = $urandom_range(0, 9);
			if (mode < 7) send_unit((i / 60) % 2 == 0);
			else send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				(i / 60) % 2 == 0);
		end
		start <= 1'b0;

		// drain and settle
		while (pending != 0 || done) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("covered %0d quaternions: directed axes, gimbal lock, extremes, random",
			beats_sent);
		$display("pitch clamp hit %0d times", clamp_seen);
		if (fail_count == 0) $display("** quaternion_to_euler_angles: PASSED **");
		else $display("** quaternion_to_euler_angles: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
hdl/qte_pkg.sv
hdl/qte_cordic.sv
hdl/quaternion_to_euler_angles.sv
dv/quaternion_to_euler_angles_checker.sv
dv/quaternion_to_euler_angles_tb.sv
